@@ design/mm_pkg.sv @@
package mm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int ADDR_W      = 2 * IDX_W;
    localparam int DEPTH       = MAX_DIM * MAX_DIM;
    localparam int DATA_W      = 32;
    localparam int DIM_W       = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int REG_IDX_W   = 2;

    localparam logic [REG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROWS_B     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_COLS_B     = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [DIM_W-1:0] rows_a;
        logic [DIM_W-1:0] inner_size;
        logic [DIM_W-1:0] rows_b;
        logic [DIM_W-1:0] cols_b;
    } t_dims;

    // tag that travels with each read through the multiply-accumulate pipe
    typedef struct packed {
        logic             valid;
        logic             kfirst;
        logic             klast;
        logic             last;
        logic             err;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } t_tag;

    // dimension register to last walk index: 0 acts as 1, above MAX_DIM as MAX_DIM
    function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] d);
        logic [IDX_W-1:0] res;
        if (d == '0) begin
            res = '0;
        end else if (d > DIM_W'(MAX_DIM)) begin
            res = IDX_W'(MAX_DIM - 1);
        end else begin
            res = IDX_W'(d - DIM_W'(1));
        end
        return res;
    endfunction

endpackage

@@ design/mm_ram.sv @@
module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/mm_queue.sv @@
module mm_queue
    import mm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd               r_buf [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [PTR_W:0]     r_count, n_count;
    logic               push_ok;
    logic               pop_ok;

    assign o_ready = (r_count != (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_buf[r_rptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wptr  = push_ok ? PTR_W'(r_wptr + PTR_W'(1)) : r_wptr;
        n_rptr  = pop_ok ? PTR_W'(r_rptr + PTR_W'(1)) : r_rptr;
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + (PTR_W + 1)'(1);
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (push_ok) begin
            r_buf[r_wptr] <= i_cmd;
        end
    end

endmodule

@@ design/mm_front.sv @@
module mm_front
    import mm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic [IDX_W-1:0]   i_row,
    input  logic [IDX_W-1:0]   i_col,
    input  logic [DATA_W-1:0]  i_value,
    output logic               o_push,
    output t_cmd               o_cmd,
    input  logic               i_q_ready
);

    logic r_valid;
    t_cmd r_cmd;
    logic accept;
    logic known_op;

    assign o_ready = !r_valid || i_q_ready;
    assign accept  = i_valid && o_ready;
    assign o_push  = r_valid;
    assign o_cmd   = r_cmd;

    // the unused op code is dropped here and never reaches the queue
    always_comb begin
        unique case (t_op'(i_op))
            OP_LOAD_A, OP_LOAD_B, OP_COMPUTE: known_op = 1'b1;
            default:                          known_op = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= known_op;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
        if (accept) begin
            r_cmd.op    <= t_op'(i_op);
            r_cmd.addr  <= {i_row, i_col};
            r_cmd.value <= i_value;
        end
    end

endmodule

@@ design/mm_back.sv @@
module mm_back
    import mm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    input  t_dims             i_dims,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_product,
    output logic [IDX_W-1:0]  o_out_row,
    output logic [IDX_W-1:0]  o_out_col,
    output logic              o_last,
    output logic              o_error
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_i, n_i, r_j, n_j, r_k, n_k;
    logic [IDX_W-1:0]   r_m_last, r_n_last, r_p_last;
    logic               start;
    logic               adv;
    t_tag               issue;
    t_tag               r_s1, r_s2;
    logic [DATA_W-1:0]  r_prod;
    logic [DATA_W-1:0]  r_acc;
    logic [DATA_W-1:0]  sum;
    logic [DATA_W-1:0]  a_rdata, b_rdata;
    logic               we_a, we_b;
    logic               mismatch;

    logic               r_out_valid;
    logic [DATA_W-1:0]  r_product;
    logic [IDX_W-1:0]   r_out_row, r_out_col;
    logic               r_last, r_error;

    // whole pipe holds while a finished result waits at the output
    assign adv      = !r_out_valid || i_ready;
    assign mismatch = (i_dims.inner_size != i_dims.rows_b);

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        o_cmd_pop = 1'b0;
        start     = 1'b0;
        we_a      = 1'b0;
        we_b      = 1'b0;
        issue     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_LOAD_A: begin
                            we_a      = 1'b1;
                            o_cmd_pop = 1'b1;
                        end
                        OP_LOAD_B: begin
                            we_b      = 1'b1;
                            o_cmd_pop = 1'b1;
                        end
                        OP_COMPUTE: begin
                            if (mismatch) begin
                                if (adv) begin
                                    o_cmd_pop    = 1'b1;
                                    issue.valid  = 1'b1;
                                    issue.kfirst = 1'b1;
                                    issue.klast  = 1'b1;
                                    issue.last   = 1'b1;
                                    issue.err    = 1'b1;
                                end
                            end else begin
                                o_cmd_pop = 1'b1;
                                start     = 1'b1;
                                n_i       = '0;
                                n_j       = '0;
                                n_k       = '0;
                                n_state   = ST_WALK;
                            end
                        end
                        default: o_cmd_pop = 1'b1;
                    endcase
                end
            end
            ST_WALK: begin
                if (adv) begin
                    issue.valid  = 1'b1;
                    issue.kfirst = (r_k == '0);
                    issue.klast  = (r_k == r_n_last);
                    issue.last   = (r_i == r_m_last) && (r_j == r_p_last);
                    issue.row    = r_i;
                    issue.col    = r_j;
                    if (r_k == r_n_last) begin
                        n_k = '0;
                        if (r_j == r_p_last) begin
                            n_j = '0;
                            if (r_i == r_m_last) begin
                                n_state = ST_IDLE;
                            end else begin
                                n_i = r_i + IDX_W'(1);
                            end
                        end else begin
                            n_j = r_j + IDX_W'(1);
                        end
                    end else begin
                        n_k = r_k + IDX_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    mm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (i_cmd.addr),
        .i_wdata (i_cmd.value),
        .i_re    (adv),
        .i_raddr ({r_i, r_k}),
        .o_rdata (a_rdata)
    );

    mm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (i_cmd.addr),
        .i_wdata (i_cmd.value),
        .i_re    (adv),
        .i_raddr ({r_k, r_j}),
        .o_rdata (b_rdata)
    );

    assign sum = (r_s2.kfirst ? '0 : r_acc) + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_s1        <= '0;
            r_s2        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (adv) begin
                r_s1        <= issue;
                r_s2        <= r_s1;
                r_out_valid <= r_s2.valid && r_s2.klast;
            end
        end
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
        if (start) begin
            r_m_last <= dim_last(i_dims.rows_a);
            r_n_last <= dim_last(i_dims.inner_size);
            r_p_last <= dim_last(i_dims.cols_b);
        end
        if (adv) begin
            r_prod <= DATA_W'(a_rdata * b_rdata);
            if (r_s2.valid) begin
                r_acc <= sum;
            end
            if (r_s2.valid && r_s2.klast) begin
                r_product <= r_s2.err ? '0 : sum;
                r_out_row <= r_s2.row;
                r_out_col <= r_s2.col;
                r_last    <= r_s2.last;
                r_error   <= r_s2.err;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_product = r_product;
    assign o_out_row = r_out_row;
    assign o_out_col = r_out_col;
    assign o_last    = r_last;
    assign o_error   = r_error;

endmodule

@@ design/matrix_multiply_unit.sv @@
// Integer matrix multiplier: load requests write one 32-bit element of A or
// B (address row, col) and are taken one per cycle while the queue has room;
// a compute request emits the rows_a x cols_b product elements in row-major
// order, each the wrapped 32-bit sum over inner_size products, with last set
// on the final one. The walk reads one A and one B element per cycle, holding
// while a result waits, from single-port-read RAMs into one 32x32 multiplier;
// each result passes the RAM read, product and output registers. If inner_size
// differs from rows_b, one result with error set is emitted instead. Dimensions
// are set over the APB port (rows_a 0x0, inner_size 0x4, rows_b 0x8, cols_b
// 0xC); the user must set them only while the unit is idle, which the block
// does not enforce; 0 acts as 1 and values above 8 act as 8 for the walk.
module matrix_multiply_unit
    import mm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic [IDX_W-1:0]   i_row,
    input  logic [IDX_W-1:0]   i_col,
    input  logic [DATA_W-1:0]  i_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [DATA_W-1:0]  o_product,
    output logic [IDX_W-1:0]   o_out_row,
    output logic [IDX_W-1:0]   o_out_col,
    output logic               o_last,
    output logic               o_error,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_dims              r_dims;
    logic               cfg_we;
    logic [REG_IDX_W-1:0] reg_idx;
    logic               f_push;
    t_cmd               f_cmd;
    logic               q_ready;
    logic               q_valid;
    t_cmd               q_cmd;
    logic               q_pop;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.rows_a     <= DIM_W'(1);
            r_dims.inner_size <= DIM_W'(1);
            r_dims.rows_b     <= DIM_W'(1);
            r_dims.cols_b     <= DIM_W'(1);
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_ROWS_A:     r_dims.rows_a     <= pwdata[DIM_W-1:0];
                REG_INNER_SIZE: r_dims.inner_size <= pwdata[DIM_W-1:0];
                REG_ROWS_B:     r_dims.rows_b     <= pwdata[DIM_W-1:0];
                REG_COLS_B:     r_dims.cols_b     <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ROWS_A:     prdata = PDATA_W'(r_dims.rows_a);
            REG_INNER_SIZE: prdata = PDATA_W'(r_dims.inner_size);
            REG_ROWS_B:     prdata = PDATA_W'(r_dims.rows_b);
            REG_COLS_B:     prdata = PDATA_W'(r_dims.cols_b);
            default:        prdata = '0;
        endcase
    end

    mm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_op      (i_op),
        .i_row     (i_row),
        .i_col     (i_col),
        .i_value   (i_value),
        .o_push    (f_push),
        .o_cmd     (f_cmd),
        .i_q_ready (q_ready)
    );

    mm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_cmd   (f_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    mm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_dims      (r_dims),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_product   (o_product),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_last      (o_last),
        .o_error     (o_error)
    );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import mm_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         ITEM_TARGET    = 270;
    localparam int         RESET_CYCLES   = 6;
    localparam int         SETTLE_CYCLES  = 24;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         DIM_MAX_CODE   = (1 << DIM_W) - 1;

    typedef struct packed {
        logic [DATA_W-1:0] product;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic              last;
        logic              err;
    } prod_elem_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_op = '0;
    logic [IDX_W-1:0]   i_row = '0;
    logic [IDX_W-1:0]   i_col = '0;
    logic [DATA_W-1:0]  i_value = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [DATA_W-1:0]  o_product;
    logic [IDX_W-1:0]   o_out_row;
    logic [IDX_W-1:0]   o_out_col;
    logic               o_last;
    logic               o_error;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // mirror of the unit: element stores, which entries hold data, dimension registers
    logic [DATA_W-1:0] mat_a [MAX_DIM][MAX_DIM];
    logic [DATA_W-1:0] mat_b [MAX_DIM][MAX_DIM];
    bit                a_loaded [MAX_DIM][MAX_DIM];
    bit                b_loaded [MAX_DIM][MAX_DIM];
    t_dims             dims = {4'd1, 4'd1, 4'd1, 4'd1};

    prod_elem_t pending_products[$];

    bit idle_en = 1'b1;
    int fail_count = 0;
    int requests_sent = 0;
    int products_checked = 0;
    int size_errors_checked = 0;
    int settings_used = 0;

    matrix_multiply_unit dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_op      (i_op),
        .i_row     (i_row),
        .i_col     (i_col),
        .i_value   (i_value),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_product (o_product),
        .o_out_row (o_out_row),
        .o_out_col (o_out_col),
        .o_last    (o_last),
        .o_error   (o_error),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // effective walk length: 0 walks as 1, anything above MAX_DIM as MAX_DIM
    function automatic int walk_len(input logic [DIM_W-1:0] d);
        if (d == '0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return int'(d);
    endfunction

    function automatic void apply_request(input logic [1:0] op, input logic [IDX_W-1:0] row,
                                          input logic [IDX_W-1:0] col,
                                          input logic [DATA_W-1:0] value);
        int                m, n, p;
        logic [DATA_W-1:0] acc;
        prod_elem_t        elem;
        case (op)
            OP_LOAD_A: begin
                mat_a[row][col] = value;
                a_loaded[row][col] = 1'b1;
            end
            OP_LOAD_B: begin
                mat_b[row][col] = value;
                b_loaded[row][col] = 1'b1;
            end
            OP_COMPUTE: begin
                // raw register compare, before any clamping
                if (dims.inner_size != dims.rows_b) begin
                    elem = '0;
                    elem.last = 1'b1;
                    elem.err = 1'b1;
                    pending_products.push_back(elem);
                end else begin
                    m = walk_len(dims.rows_a);
                    n = walk_len(dims.inner_size);
                    p = walk_len(dims.cols_b);
                    for (int i = 0; i < m; i++) begin
                        for (int j = 0; j < p; j++) begin
                            acc = '0;
                            for (int k = 0; k < n; k++) acc = acc + mat_a[i][k] * mat_b[k][j];
                            elem.product = acc;
                            elem.row = IDX_W'(i);
                            elem.col = IDX_W'(j);
                            elem.last = (i == m - 1) && (j == p - 1);
                            elem.err = 1'b0;
                            pending_products.push_back(elem);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 70) return DIM_W'($urandom_range(1, 3));
        if (r < 78) return '0;
        if (r < 92) return DIM_W'($urandom_range(4, MAX_DIM));
        return DIM_W'($urandom_range(MAX_DIM + 1, DIM_MAX_CODE));
    endfunction

    // mostly inside the active region, sometimes anywhere in the store
    function automatic logic [IDX_W-1:0] pick_index(input int limit);
        if ($urandom_range(99) < 75) return IDX_W'($urandom_range(0, limit - 1));
        return IDX_W'($urandom);
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [IDX_W-1:0] row,
                                input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value);
        while (idle_en && $urandom_range(99) < 19) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_row <= row;
        i_col <= col;
        i_value <= value;
        do @(posedge i_clk); while (!o_ready);
        apply_request(op, row, col, value);
        if (op != OP_UNUSED) requests_sent++;
    endtask

    // never returns without waiting on the clock, so a following request never re-raises valid
    // in the same step that lowered it
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_products.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= PDATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] inner,
                            input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
        write_register(REG_ROWS_A, ra);
        write_register(REG_INNER_SIZE, inner);
        write_register(REG_ROWS_B, rb);
        write_register(REG_COLS_B, cb);
        dims.rows_a = ra;
        dims.inner_size = inner;
        dims.rows_b = rb;
        dims.cols_b = cb;
        settings_used++;
    endtask

    // a compute must never read an entry that was never loaded
    task automatic fill_operands();
        int m, n, p;
        if (dims.inner_size != dims.rows_b) return;
        m = walk_len(dims.rows_a);
        n = walk_len(dims.inner_size);
        p = walk_len(dims.cols_b);
        for (int i = 0; i < m; i++)
            for (int k = 0; k < n; k++)
                if (!a_loaded[i][k]) send_request(OP_LOAD_A, IDX_W'(i), IDX_W'(k), pick_value());
        for (int k = 0; k < n; k++)
            for (int j = 0; j < p; j++)
                if (!b_loaded[k][j]) send_request(OP_LOAD_B, IDX_W'(k), IDX_W'(j), pick_value());
    endtask

    task automatic test_wrap_extremes();
        send_request(OP_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
        send_request(OP_LOAD_B, 3'd0, 3'd0, 32'hFFFF_FFFF);
        send_request(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
        send_request(OP_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_request(OP_LOAD_A, 3'd7, 3'd7, 32'h7FFF_FFFF);
        send_request(OP_LOAD_B, 3'd7, 3'd7, 32'hFFFF_FFFF);
        // unused opcode aimed at B(0,0): the next product shows whether it leaked
        send_request(OP_UNUSED, 3'd0, 3'd0, 32'h0000_0001);
        send_request(OP_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic test_size_mismatch();
        set_dims(4'd1, 4'd2, 4'd1, 4'd1);
        send_request(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
        drain_results();
        // 0 and 1 walk alike but still differ as register values
        set_dims(4'd1, 4'd0, 4'd1, 4'd1);
        send_request(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
        drain_results();
        set_dims(4'd3, 4'd15, 4'd9, 4'd3);
        send_request(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
        drain_results();
    endtask

    task automatic test_dim_clamp();
        set_dims(4'd0, 4'd0, 4'd0, 4'd0);
        send_request(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
        drain_results();
        set_dims(4'd2, 4'd2, 4'd2, 4'd2);
        fill_operands();
        send_request(OP_COMPUTE, 3'd0, 3'd0, 32'h0);
        drain_results();
    endtask

    task automatic test_random_traffic();
        logic [DIM_W-1:0] ra, inner, rb, cb;
        bit               big_done;
        int               op_pick;
        big_done = 1'b0;
        while (requests_sent < ITEM_TARGET || !big_done) begin
            idle_en = !(requests_sent >= 90 && requests_sent < 160);
            ra = pick_dim();
            inner = pick_dim();
            cb = pick_dim();
            rb = inner;
            if (!big_done && requests_sent >= 150) begin
                // full 8x8x8 walk, with the inner size given above the maximum
                ra = 4'd8;
                inner = 4'd12;
                rb = 4'd12;
                cb = 4'd15;
                big_done = 1'b1;
            end else if ($urandom_range(99) < 10) begin
                do rb = DIM_W'($urandom); while (rb == inner);
            end
            set_dims(ra, inner, rb, cb);
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 6)) begin
                    op_pick = $urandom_range(99);
                    if (op_pick < 8)
                        send_request(OP_UNUSED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
                    else if (op_pick < 54)
                        send_request(OP_LOAD_A, pick_index(walk_len(ra)),
                                     pick_index(walk_len(inner)), pick_value());
                    else
                        send_request(OP_LOAD_B, pick_index(walk_len(rb)),
                                     pick_index(walk_len(cb)), pick_value());
                end
                fill_operands();
                send_request(OP_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), $urandom);
            end
            drain_results();
        end
        idle_en = 1'b1;
    endtask

    always @(posedge i_clk) begin : result_check
        prod_elem_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_products.size() == 0) begin
                $error("unexpected result: product %0d at (%0d,%0d) last %0b error %0b",
                       $signed(o_product), o_out_row, o_out_col, o_last, o_error);
                fail_count++;
            end else begin
                want = pending_products.pop_front();
                if (o_product !== want.product) begin
                    $error("product: expected %0d, got %0d", $signed(want.product),
                           $signed(o_product));
                    fail_count++;
                end
                if (o_out_row !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, o_out_row);
                    fail_count++;
                end
                if (o_out_col !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, o_out_col);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_last);
                    fail_count++;
                end
                if (o_error !== want.err) begin
                    $error("error: expected %0b, got %0b", want.err, o_error);
                    fail_count++;
                end
                if (want.err) size_errors_checked++;
                else products_checked++;
            end
        end
        i_ready <= !(idle_en && $urandom_range(99) < 19);
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_wrap_extremes();
        test_size_mismatch();
        test_dim_clamp();
        test_random_traffic();
        drain_results();
        $display("Sent %0d load/compute requests across %0d dimension settings (0, 1..8, >8).",
                 requests_sent, settings_used);
        $display("Checked %0d product elements and %0d size-mismatch results.",
                 products_checked, size_errors_checked);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
